### design/psu_pkg.sv
// psu_pkg: shared types, codes and the Paeth predictor for the PNG scanline unfilter.
// No dependencies; imported by psu_front, psu_back and the top level.
`default_nettype none

package psu_pkg;

    localparam int BPP_W   = 4;   // bytes_per_pixel register width
    localparam int LEN_W   = 13;  // line_bytes register width
    localparam int CFG_W   = 13;  // config write data, widest register
    localparam int FUNC_W  = 3;

    // config register indexes
    localparam logic CFG_IDX_BPP = 1'b0;
    localparam logic CFG_IDX_LEN = 1'b1;

    // filter type codes; anything else decodes as none
    typedef enum logic [FUNC_W-1:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // classified byte passed from the front end to the reconstruction stage
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [7:0]        raw;
        logic              first_row;  // prior row reads as zero
        logic              left_zero;  // within the first bpp bytes of the line
        logic              line_end;
    } psu_ctrl_t;

    // Paeth predictor, tie order left, up, up-left
    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [9:0] sab;
        logic [9:0] c2;
        logic [7:0] sel;
        begin
            pa  = (b > c) ? 10'(b - c) : 10'(c - b);
            pb  = (a > c) ? 10'(a - c) : 10'(c - a);
            sab = 10'(a) + 10'(b);
            c2  = {1'b0, c, 1'b0};
            pc  = (sab > c2) ? (sab - c2) : (c2 - sab);
            if ((pa <= pb) && (pa <= pc)) begin
                sel = a;
            end else if (pb <= pc) begin
                sel = b;
            end else begin
                sel = c;
            end
            return sel;
        end
    endfunction

endpackage

`default_nettype wire

### design/psu_front.sv
// psu_front: accepts filtered bytes, tracks line position and row, classifies each byte.
// Depends on psu_pkg.
`default_nettype none

module psu_front #(
    parameter int AW = 12,
    parameter int CW = 13
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [2:0]        func,
    input  wire logic [7:0]        filtered_byte,
    input  wire logic              image_start,
    input  wire logic [3:0]        bpp_eff,
    input  wire logic [CW-1:0]     len_eff,
    output psu_pkg::psu_ctrl_t     ctrl,
    output logic [AW-1:0]          addr
);
    import psu_pkg::*;

    logic [AW-1:0] pos_reg, pos_next;
    logic          first_reg, first_next;
    logic [AW-1:0] pos_eff;
    logic          first_eff;
    logic          last;

    always_comb begin
        pos_eff   = image_start ? '0 : pos_reg;
        first_eff = image_start | first_reg;
        last      = (CW'(pos_eff) + CW'(1)) >= len_eff;

        ctrl.func      = func;
        ctrl.raw       = filtered_byte;
        ctrl.first_row = first_eff;
        ctrl.left_zero = CW'(pos_eff) < CW'(bpp_eff);
        ctrl.line_end  = last;
        addr           = pos_eff;

        pos_next   = pos_reg;
        first_next = first_reg;
        if (accept) begin
            if (last) begin
                pos_next   = '0;
                first_next = 1'b0;
            end else begin
                pos_next   = pos_eff + AW'(1);
                first_next = first_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            first_reg <= 1'b1;
        end else begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

### design/psu_queue.sv
// psu_queue: short register FIFO decoupling the front end from reconstruction.
// Depends on psu_pkg only by convention; no package content used.
`default_nettype none

module psu_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       pop,
    output logic [WIDTH-1:0]                rdata,
    output logic                            full,
    output logic                            not_empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);
    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign rdata     = slot_reg[rd_ptr_reg];
    assign full      = (count_reg == NW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

### design/psu_back.sv
// psu_back: prior-line store, left/up-left history and the filter reconstruction stage.
// Depends on psu_pkg (control struct, filter codes, Paeth predictor).
`default_nettype none

module psu_back #(
    parameter int AW      = 12,
    parameter int MAX_BPP = 8,
    parameter int HW      = 3
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire psu_pkg::psu_ctrl_t q_ctrl,
    input  wire logic [AW-1:0]      q_addr,
    output logic                    q_pop,
    input  wire logic [HW-1:0]      bpp_idx,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tlast
);
    import psu_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [7:0]  line_mem [DEPTH];

    logic        b2_valid_reg, b2_valid_next;
    psu_ctrl_t   b2_ctrl_reg;
    logic [AW-1:0] b2_addr_reg;
    logic        fwd_reg;
    logic [7:0]  rd_data_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic [7:0]  left_hist_reg   [MAX_BPP];
    logic [7:0]  upleft_hist_reg [MAX_BPP];

    logic        retire;
    logic        load;
    logic [7:0]  up;
    logic [7:0]  left;
    logic [7:0]  upleft;
    logic [8:0]  avg_sum;
    logic [7:0]  pred;
    logic [7:0]  res;

    assign retire = b2_valid_reg && (!out_valid_reg || m_tready);
    assign load   = q_valid && (!b2_valid_reg || retire);
    assign q_pop  = load;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    // a store read that collides with the write of the retiring byte takes the new value
    always_comb begin
        up      = b2_ctrl_reg.first_row ? 8'd0 : (fwd_reg ? left_hist_reg[0] : rd_data_reg);
        left    = b2_ctrl_reg.left_zero ? 8'd0 : left_hist_reg[bpp_idx];
        upleft  = b2_ctrl_reg.left_zero ? 8'd0 : upleft_hist_reg[bpp_idx];
        avg_sum = {1'b0, left} + {1'b0, up};
        unique case (b2_ctrl_reg.func)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = up;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth_pred(left, up, upleft);
            default:    pred = 8'd0;
        endcase
        res = b2_ctrl_reg.raw + pred;
    end

    always_comb begin
        b2_valid_next = b2_valid_reg;
        if (load) begin
            b2_valid_next = 1'b1;
        end else if (retire) begin
            b2_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (retire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            for (int k = 0; k < MAX_BPP; k++) begin
                left_hist_reg[k]   <= 8'd0;
                upleft_hist_reg[k] <= 8'd0;
            end
        end else begin
            b2_valid_reg  <= b2_valid_next;
            out_valid_reg <= out_valid_next;
            if (load) begin
                fwd_reg <= retire && (b2_addr_reg == q_addr);
            end
            if (retire) begin
                for (int k = MAX_BPP - 1; k > 0; k--) begin
                    left_hist_reg[k]   <= left_hist_reg[k-1];
                    upleft_hist_reg[k] <= upleft_hist_reg[k-1];
                end
                left_hist_reg[0]   <= res;
                upleft_hist_reg[0] <= up;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            b2_ctrl_reg <= q_ctrl;
            b2_addr_reg <= q_addr;
        end
        if (retire) begin
            out_byte_reg <= res;
            out_last_reg <= b2_ctrl_reg.line_end;
        end
    end

    // prior-line store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (retire) begin
            line_mem[b2_addr_reg] <= res;
        end
        if (load) begin
            rd_data_reg <= line_mem[q_addr];
        end
    end

endmodule

`default_nettype wire

### design/png_scanline_unfilter.sv
// png_scanline_unfilter: top level of the PNG scanline unfilter (filter reconstruction).
// Depends on psu_pkg, psu_front, psu_queue, psu_back.
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    tdata: filtered_byte; tuser: func, image_start
//  m_        out  m_tvalid / m_tready    tdata: pixel_byte; tlast: line_end
//  cfg_      in   cfg_we (no wait)       cfg_addr: 0 bytes_per_pixel, 1 line_bytes
//
// One byte per clock sustained while the output does not stall. The accepting edge
// writes the byte into the queue; from there it moves into reconstruction with its
// line-store read, then is reconstructed into the output register that drives m_tvalid.
// The loop that sets the rate is the reconstruction stage: its result feeds the left
// history that the very next byte reads when bytes_per_pixel is 1.
// Reset is synchronous, active low; the line store is not cleared and needs no sweep.
// Output stalls back up through the reconstruction stage into the queue; s_tready drops
// only once the queue is full.
`default_nettype none

module png_scanline_unfilter #(
    parameter int MAX_LINE_BYTES = 4096,
    parameter int MAX_BPP        = 8,
    parameter int QUEUE_DEPTH    = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // input transactions
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // [7:0] filtered_byte
    input  wire logic [3:0]               s_tuser,   // [2:0] func, [3] image_start
    // result transactions
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] pixel_byte
    output logic                          m_tlast,   // line_end
    // configuration writes
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_addr,
    input  wire logic [psu_pkg::CFG_W-1:0] cfg_wdata
);
    import psu_pkg::*;

    localparam int AW  = $clog2(MAX_LINE_BYTES);
    localparam int CW  = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam int HW  = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
    localparam int QW  = $bits(psu_ctrl_t) + AW;
    localparam int NW  = $clog2(QUEUE_DEPTH + 1);

    // configuration registers
    logic [BPP_W-1:0] bpp_reg;
    logic [LEN_W-1:0] len_reg;
    logic [BPP_W-1:0] bpp_eff;
    logic [CW-1:0]    len_eff;
    logic [HW-1:0]    bpp_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg <= BPP_W'(1);
            len_reg <= LEN_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_IDX_BPP: bpp_reg <= cfg_wdata[BPP_W-1:0];
                CFG_IDX_LEN: len_reg <= cfg_wdata[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    // out-of-range settings clamp to the nearest legal value
    always_comb begin
        if (bpp_reg == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (bpp_reg > BPP_W'(MAX_BPP)) begin
            bpp_eff = BPP_W'(MAX_BPP);
        end else begin
            bpp_eff = bpp_reg;
        end
        if (len_reg == '0) begin
            len_eff = CW'(1);
        end else if (CW'(len_reg) > CW'(MAX_LINE_BYTES)) begin
            len_eff = CW'(MAX_LINE_BYTES);
        end else begin
            len_eff = CW'(len_reg);
        end
        bpp_idx = HW'(bpp_eff - BPP_W'(1));
    end

    // front end
    logic          s_accept;
    psu_ctrl_t     f_ctrl;
    logic [AW-1:0] f_addr;
    logic          q_full;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    psu_front #(
        .AW (AW),
        .CW (CW)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .func          (s_tuser[2:0]),
        .filtered_byte (s_tdata),
        .image_start   (s_tuser[3]),
        .bpp_eff       (bpp_eff),
        .len_eff       (len_eff),
        .ctrl          (f_ctrl),
        .addr          (f_addr)
    );

    // decoupling queue
    logic [QW-1:0] q_rdata;
    logic          q_valid;
    logic          q_pop;
    logic [NW-1:0] q_count;
    psu_ctrl_t     q_ctrl;
    logic [AW-1:0] q_addr;

    assign {q_addr, q_ctrl} = q_rdata;

    psu_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .wdata     ({f_addr, f_ctrl}),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .full      (q_full),
        .not_empty (q_valid),
        .count     (q_count)
    );

    // reconstruction
    psu_back #(
        .AW      (AW),
        .MAX_BPP (MAX_BPP),
        .HW      (HW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ctrl   (q_ctrl),
        .q_addr   (q_addr),
        .q_pop    (q_pop),
        .bpp_idx  (bpp_idx),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // checks
    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= NW'(QUEUE_DEPTH))
        else $error("queue occupancy beyond its depth");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_count != '0)
        else $error("queue popped while empty");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !q_pop |=> q_count == $past(q_count) + NW'(1))
        else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

### test/tb_png_scanline_unfilter.sv
// tb_png_scanline_unfilter: self-checking testbench for the PNG scanline unfilter.
// Needs psu_pkg and png_scanline_unfilter; a scoreboard class rebuilds every pixel
// byte from the filtered stream and checks the result stream in order.
`timescale 1ns / 1ps

import psu_pkg::*;

localparam int LINE_MAX = 4096;
localparam int BPP_MAX  = 8;

typedef struct packed {
    logic [7:0] pixel;
    logic       line_end;
} pixel_t;

// Holds its own copy of the line store, the left and up-left histories and the
// row position; works out each pixel byte as its filtered byte is accepted.
class pixel_scoreboard;
    logic [7:0]  prior_row [LINE_MAX];
    bit          row_written [LINE_MAX];
    logic [7:0]  left_hist [BPP_MAX];
    logic [7:0]  upleft_hist [BPP_MAX];
    int unsigned pos;
    bit          first_row;
    int unsigned bpp_reg;
    int unsigned len_reg;
    pixel_t      expected_pixels [$];
    int          failures;
    int          checked;

    function new();
        foreach (row_written[i]) begin
            row_written[i] = 1'b0;
            prior_row[i]   = 8'h00;
        end
        foreach (left_hist[i]) begin
            left_hist[i]   = 8'h00;
            upleft_hist[i] = 8'h00;
        end
        pos       = 0;
        first_row = 1'b1;
        bpp_reg   = 1;
        len_reg   = 1;
        failures  = 0;
        checked   = 0;
    endfunction

    function void accept_filtered(logic [2:0] func, logic [7:0] raw, logic img);
        int unsigned bpp, len, a, b, c, pa, pb, pc, guess;
        logic [7:0]  pix;
        bit          last;
        bpp = (bpp_reg == 0) ? 1 : (bpp_reg > BPP_MAX) ? BPP_MAX : bpp_reg;
        len = (len_reg == 0) ? 1 : (len_reg > LINE_MAX) ? LINE_MAX : len_reg;
        if (img) begin
            pos       = 0;
            first_row = 1'b1;
        end
        b = first_row ? 0 : prior_row[pos];
        if (pos < bpp) begin
            a = 0;
            c = 0;
        end else begin
            a = left_hist[bpp-1];
            c = upleft_hist[bpp-1];
        end
        // Paeth distances: |b-c|, |a-c|, |a+b-2c|
        pa = (b > c) ? b - c : c - b;
        pb = (a > c) ? a - c : c - a;
        pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - (a + b);
        case (func)
            FILT_SUB:   guess = a;
            FILT_UP:    guess = b;
            FILT_AVG:   guess = (a + b) >> 1;
            FILT_PAETH: guess = (pa <= pb && pa <= pc) ? a : (pb <= pc) ? b : c;
            default:    guess = 0;  // none, and the unused codes
        endcase
        pix = 8'(raw + guess);
        for (int k = BPP_MAX - 1; k > 0; k--) begin
            left_hist[k]   = left_hist[k-1];
            upleft_hist[k] = upleft_hist[k-1];
        end
        left_hist[0]     = pix;
        upleft_hist[0]   = 8'(b);
        prior_row[pos]   = pix;
        row_written[pos] = 1'b1;
        last = (pos + 1 >= len);
        if (last) begin
            pos       = 0;
            first_row = 1'b0;
        end else begin
            pos++;
        end
        expected_pixels.push_back('{pixel: pix, line_end: last});
    endfunction

    function void check_pixel(logic [7:0] data, logic last);
        pixel_t want;
        if (expected_pixels.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: pixel %02h line_end %b", data, last);
            return;
        end
        want = expected_pixels.pop_front();
        checked++;
        if (data !== want.pixel || last !== want.line_end) begin
            failures++;
            if (failures <= 10)
                $display("result %0d: expected pixel %02h line_end %b, got %02h %b",
                         checked, want.pixel, want.line_end, data, last);
        end
    endfunction
endclass

module tb_png_scanline_unfilter;

    localparam int QUIET_LIMIT  = 400;
    localparam int ITEMS_TARGET = 1750;
    localparam logic [2:0] FILT_RESERVED [3] = '{3'd5, 3'd6, 3'd7};

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'h00;
    logic [3:0]       s_tuser   = 4'h0;   // [2:0] func, [3] image_start
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;            // [7:0] pixel_byte
    logic             m_tlast;
    logic             cfg_we    = 1'b0;
    logic             cfg_addr  = CFG_IDX_BPP;
    logic [CFG_W-1:0] cfg_wdata = '0;

    pixel_scoreboard sb = new();

    bit send_calm = 1'b0;   // no gaps between input transactions
    bit take_calm = 1'b0;   // no stalls on the result side
    int items_sent      = 0;
    int lines_seen      = 0;
    int configs_written = 0;
    int quiet_cycles    = 0;

    png_scanline_unfilter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // One input transaction. A byte that would read a store entry never written
    // (line grown between rows) is turned into an image start instead.
    task automatic send_filtered(input logic [2:0] func, input logic [7:0] raw,
                                 input logic img);
        int gap;
        if (!img && !sb.first_row && !sb.row_written[sb.pos])
            img = 1'b1;
        gap = send_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tuser  <= {img, func};
        do @(posedge aclk); while (!s_tready);
        sb.accept_filtered(func, raw, img);
        items_sent++;
    endtask

    // Hold the input off until every pixel owed has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(input int unsigned bpp_val, input int unsigned len_val);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_IDX_BPP;
        cfg_wdata <= CFG_W'(bpp_val);
        @(posedge aclk);
        sb.bpp_reg = bpp_val & 32'hF;
        cfg_addr  <= CFG_IDX_LEN;
        cfg_wdata <= CFG_W'(len_val);
        @(posedge aclk);
        sb.len_reg = len_val & 32'h1FFF;
        cfg_we    <= 1'b0;
        configs_written++;
    endtask

    // Whole rows with one filter per row, the odd stray filter byte, rare stray
    // image starts and the occasional full drain.
    task automatic send_rows(input int unsigned rows, input bit new_image);
        logic [2:0] row_func;
        logic [2:0] f;
        bit         first;
        first = 1'b1;
        repeat (rows) begin
            row_func = ($urandom_range(0, 9) == 0) ? FILT_RESERVED[$urandom_range(0, 2)]
                                                   : 3'($urandom_range(0, 4));
            do begin
                f = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : row_func;
                send_filtered(f, 8'($urandom),
                              (new_image && first) || ($urandom_range(0, 63) == 0));
                first = 1'b0;
                if ($urandom_range(0, 199) == 0)
                    drain();
            end while (sb.pos != 0);
        end
    endtask

    // Nothing accepted on either side for too long: hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d pixels owed",
                         quiet_cycles, sb.expected_pixels.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result side: random stalls, with calm stretches chosen every 64 results.
    initial begin : result_sink
        int stall;
        @(posedge aresetn);
        forever begin
            stall = take_calm ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_pixel(m_tdata, m_tlast);
            if (m_tlast)
                lines_seen++;
            if (sb.checked % 64 == 0)
                take_calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every filter code, the reserved ones too, over three rows, byte extremes
        write_config(2, 5);
        send_filtered(FILT_NONE,  8'h00, 1'b1);
        send_filtered(FILT_SUB,   8'hFF, 1'b0);
        send_filtered(FILT_SUB,   8'h80, 1'b0);
        send_filtered(FILT_AVG,   8'h7F, 1'b0);
        send_filtered(FILT_PAETH, 8'h01, 1'b0);
        send_filtered(FILT_UP,    8'hFF, 1'b0);
        send_filtered(FILT_AVG,   8'hFF, 1'b0);
        send_filtered(FILT_PAETH, 8'h55, 1'b0);
        send_filtered(FILT_PAETH, 8'hAA, 1'b0);
        send_filtered(FILT_RESERVED[2], 8'h33, 1'b0);
        send_filtered(FILT_RESERVED[0], 8'hC4, 1'b0);
        send_filtered(FILT_RESERVED[1], 8'h3B, 1'b0);
        send_filtered(FILT_UP,    8'h0F, 1'b0);
        // zero distance and zero length clamp to one: each byte is a line
        write_config(0, 0);
        send_filtered(FILT_SUB,   8'h10, 1'b0);
        send_filtered(FILT_UP,    8'h20, 1'b0);
        send_filtered(FILT_AVG,   8'h30, 1'b0);
        // distance 15 clamps to 8; the last byte reaches the far end of the history
        write_config(15, 9);
        for (int k = 0; k < 9; k++)
            send_filtered((k == 8) ? FILT_SUB : FILT_NONE, 8'($urandom), k == 0);

        // Length 8191 clamps to 4096: a long first row, then shrink below the
        // current position so the next byte ends the line
        write_config(3, 8191);
        for (int k = 0; k < 600; k++)
            send_filtered(3'($urandom_range(0, 4)), 8'($urandom), k == 0);
        write_config(5, 100);
        send_rows(3, 1'b0);

        // Random phases of images with random settings
        while (items_sent < ITEMS_TARGET) begin
            case ($urandom_range(0, 5))
                0:       write_config(0, $urandom_range(2, 24));
                1:       write_config(15, $urandom_range(2, 24));
                2:       write_config(BPP_MAX, $urandom_range(9, 40));
                3:       write_config(1, $urandom_range(0, 1));
                4:       write_config($urandom_range(1, 8), $urandom_range(60, 160));
                default: write_config($urandom_range(0, 15), $urandom_range(1, 24));
            endcase
            send_calm = ($urandom_range(0, 3) == 0);
            for (int r = $urandom_range(1, 3); r > 0 && items_sent < ITEMS_TARGET; r--)
                send_rows($urandom_range(1, 5), $urandom_range(0, 3) != 0);
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("%0d filtered bytes sent over %0d register settings", items_sent,
                 configs_written);
        $display("%0d pixel bytes checked, %0d line ends, longest line 601 bytes",
                 sb.checked, lines_seen);
        if (sb.failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failures", sb.failures);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
design/psu_pkg.sv
design/psu_front.sv
design/psu_queue.sv
design/psu_back.sv
design/png_scanline_unfilter.sv
test/tb_png_scanline_unfilter.sv
